### rtl/core/csvd_pkg.sv
// ----------------------------------------------------------------------------
// csvd_pkg
// Shared types and constants of the CSV field deframer: character codes,
// the tokenizer phase encoding, and the result and decode records.
// ----------------------------------------------------------------------------
package csvd_pkg;

    // Widths fixed by the item fields
    localparam int BYTE_W      = 8;
    localparam int FNUM_W      = 4;
    localparam int CFG_W       = 4;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;
    localparam int OUT_TUSER_W = 3;

    // Default field limit and reset value of the decoding field index
    localparam int               MAX_FIELDS_DEF = 16;
    localparam logic [CFG_W-1:0] UNESC_RESET    = 4'd5;

    // Character codes
    localparam logic [BYTE_W-1:0] CH_QUOTE = 8'd34;
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'd44;
    localparam logic [BYTE_W-1:0] CH_NL    = 8'd10;
    localparam logic [BYTE_W-1:0] CH_BSL   = 8'd92;
    localparam logic [BYTE_W-1:0] CH_N     = 8'd110;

    // Result queue geometry
    localparam int QDEPTH = 3;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 2;

    // Tokenizer phase, one-hot
    typedef enum logic [7:0] {
        PH_START = 8'b0000_0001,  // first byte of a field
        PH_UNQ   = 8'b0000_0010,  // inside an unquoted field
        PH_UQ    = 8'b0000_0100,  // unquoted field, quote held
        PH_UBS   = 8'b0000_1000,  // unquoted field, backslash held
        PH_QUO   = 8'b0001_0000,  // inside a quoted field
        PH_Q1    = 8'b0010_0000,  // quoted field, one quote held
        PH_Q2    = 8'b0100_0000,  // quoted field, two quotes held
        PH_QBS   = 8'b1000_0000   // quoted field, backslash held
    } t_phase;

    // What the current byte does after any held byte is released
    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_PUT  = 2'd1,
        ACT_END  = 2'd2
    } t_act;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              byte_valid;
        logic              field_end;
        logic              record_end;
        logic [FNUM_W-1:0] field_number;
        logic              last;
    } t_result;

    typedef struct packed {
        logic [1:0] count;        // results produced, 0 to 2
        t_result    res0;
        t_result    res1;
        t_phase     phase;        // next phase
        logic       field_done;   // field closed by a comma
        logic       record_done;  // field closed by a newline
    } t_dec;

endpackage

### rtl/core/csvd_decode.sv
// ----------------------------------------------------------------------------
// csvd_decode
// Single-pass decode of one CSV byte: releases a held quote or backslash,
// classifies the current byte and forms up to two result records.
// ----------------------------------------------------------------------------
module csvd_decode (
    input  logic [csvd_pkg::BYTE_W-1:0] i_byte,
    input  csvd_pkg::t_phase            i_phase,
    input  logic [csvd_pkg::FNUM_W-1:0] i_field_num,
    input  logic                        i_decode,
    output csvd_pkg::t_dec              o_dec
);

    logic is_quote, is_comma, is_nl, is_bsl, is_n;

    // Unquoted-byte outcome
    csvd_pkg::t_act   u_act;
    logic             u_rec;
    csvd_pkg::t_phase u_ph;

    // Quoted-byte outcome
    csvd_pkg::t_act   q_act;
    csvd_pkg::t_phase q_ph;

    // Selected outcome
    logic                        pre_v;
    logic [csvd_pkg::BYTE_W-1:0] pre_b;
    csvd_pkg::t_act              act;
    logic                        rec;
    csvd_pkg::t_phase            nph;

    csvd_pkg::t_result pre_res, cur_res;

    assign is_quote = (i_byte == csvd_pkg::CH_QUOTE);
    assign is_comma = (i_byte == csvd_pkg::CH_COMMA);
    assign is_nl    = (i_byte == csvd_pkg::CH_NL);
    assign is_bsl   = (i_byte == csvd_pkg::CH_BSL);
    assign is_n     = (i_byte == csvd_pkg::CH_N);

    // Classify the byte as unquoted content
    always_comb begin
        u_rec = 1'b0;
        if (is_comma) begin
            u_act = csvd_pkg::ACT_END;
            u_ph  = csvd_pkg::PH_START;
        end else if (is_nl) begin
            u_act = csvd_pkg::ACT_END;
            u_rec = 1'b1;
            u_ph  = csvd_pkg::PH_START;
        end else if (i_decode && is_quote) begin
            u_act = csvd_pkg::ACT_NONE;
            u_ph  = csvd_pkg::PH_UQ;
        end else if (i_decode && is_bsl) begin
            u_act = csvd_pkg::ACT_NONE;
            u_ph  = csvd_pkg::PH_UBS;
        end else begin
            u_act = csvd_pkg::ACT_PUT;
            u_ph  = csvd_pkg::PH_UNQ;
        end
    end

    // Classify the byte as quoted content
    always_comb begin
        if (is_quote) begin
            q_act = csvd_pkg::ACT_NONE;
            q_ph  = csvd_pkg::PH_Q1;
        end else if (i_decode && is_bsl) begin
            q_act = csvd_pkg::ACT_NONE;
            q_ph  = csvd_pkg::PH_QBS;
        end else begin
            q_act = csvd_pkg::ACT_PUT;
            q_ph  = csvd_pkg::PH_QUO;
        end
    end

    // Pick the held-byte release and the action of the current byte
    always_comb begin
        pre_v = 1'b0;
        pre_b = csvd_pkg::CH_QUOTE;
        act   = csvd_pkg::ACT_NONE;
        rec   = 1'b0;
        nph   = csvd_pkg::PH_START;
        case (i_phase)
            csvd_pkg::PH_START: begin
                if (is_quote) begin
                    nph = csvd_pkg::PH_QUO;
                end else begin
                    act = u_act;
                    rec = u_rec;
                    nph = u_ph;
                end
            end
            csvd_pkg::PH_UNQ: begin
                act = u_act;
                rec = u_rec;
                nph = u_ph;
            end
            csvd_pkg::PH_UQ: begin
                pre_v = 1'b1;
                if (is_quote) begin
                    nph = csvd_pkg::PH_UNQ;
                end else begin
                    act = u_act;
                    rec = u_rec;
                    nph = u_ph;
                end
            end
            csvd_pkg::PH_UBS: begin
                pre_v = 1'b1;
                if (is_n) begin
                    pre_b = csvd_pkg::CH_NL;
                    nph   = csvd_pkg::PH_UNQ;
                end else begin
                    pre_b = csvd_pkg::CH_BSL;
                    act   = u_act;
                    rec   = u_rec;
                    nph   = u_ph;
                end
            end
            csvd_pkg::PH_QUO: begin
                act = q_act;
                nph = q_ph;
            end
            csvd_pkg::PH_Q1: begin
                if (is_comma) begin
                    act = csvd_pkg::ACT_END;
                end else if (is_nl) begin
                    act = csvd_pkg::ACT_END;
                    rec = 1'b1;
                end else if (i_decode && is_quote) begin
                    nph = csvd_pkg::PH_Q2;
                end else begin
                    pre_v = 1'b1;
                    act   = q_act;
                    nph   = q_ph;
                end
            end
            csvd_pkg::PH_Q2: begin
                pre_v = 1'b1;
                if (is_comma) begin
                    act = csvd_pkg::ACT_END;
                end else if (is_nl) begin
                    act = csvd_pkg::ACT_END;
                    rec = 1'b1;
                end else if (is_quote) begin
                    nph = csvd_pkg::PH_Q1;
                end else begin
                    act = q_act;
                    nph = q_ph;
                end
            end
            csvd_pkg::PH_QBS: begin
                pre_v = 1'b1;
                if (is_n) begin
                    pre_b = csvd_pkg::CH_NL;
                    nph   = csvd_pkg::PH_QUO;
                end else begin
                    pre_b = csvd_pkg::CH_BSL;
                    act   = q_act;
                    nph   = q_ph;
                end
            end
            default: begin
                nph = csvd_pkg::PH_START;
            end
        endcase
    end

    // Form the result records; a field end merges into a released byte
    always_comb begin
        pre_res.data         = pre_b;
        pre_res.byte_valid   = 1'b1;
        pre_res.field_end    = 1'b0;
        pre_res.record_end   = 1'b0;
        pre_res.field_number = i_field_num;
        pre_res.last         = 1'b0;

        cur_res.data         = i_byte;
        cur_res.byte_valid   = 1'b1;
        cur_res.field_end    = 1'b0;
        cur_res.record_end   = 1'b0;
        cur_res.field_number = i_field_num;
        cur_res.last         = 1'b1;

        o_dec.res0        = pre_res;
        o_dec.res1        = cur_res;
        o_dec.count       = 2'd0;
        o_dec.phase       = nph;
        o_dec.field_done  = 1'b0;
        o_dec.record_done = 1'b0;

        case (act)
            csvd_pkg::ACT_END: begin
                o_dec.count            = 2'd1;
                o_dec.res0.data        = pre_v ? pre_b : '0;
                o_dec.res0.byte_valid  = pre_v;
                o_dec.res0.field_end   = 1'b1;
                o_dec.res0.record_end  = rec;
                o_dec.res0.last        = 1'b1;
                o_dec.field_done       = ~rec;
                o_dec.record_done      = rec;
            end
            csvd_pkg::ACT_PUT: begin
                if (pre_v) begin
                    o_dec.count = 2'd2;
                end else begin
                    o_dec.count = 2'd1;
                    o_dec.res0  = cur_res;
                end
            end
            default: begin
                o_dec.count     = pre_v ? 2'd1 : 2'd0;
                o_dec.res0.last = 1'b1;
            end
        endcase
    end

endmodule

### rtl/core/csvd_outq.sv
// ----------------------------------------------------------------------------
// csvd_outq
// Three-entry result queue: takes up to two results per cycle from the
// decoder and hands one per cycle to the output stream while it is ready.
// ----------------------------------------------------------------------------
module csvd_outq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [1:0]                  i_push,
    input  csvd_pkg::t_result           i_res0,
    input  csvd_pkg::t_result           i_res1,
    input  logic                        i_pop,
    output csvd_pkg::t_result           o_head,
    output logic [csvd_pkg::QCNT_W-1:0] o_count
);

    csvd_pkg::t_result r_mem [csvd_pkg::QDEPTH];

    logic [csvd_pkg::QPTR_W-1:0] r_wr, n_wr, r_rd, n_rd, wr_next;
    logic [csvd_pkg::QCNT_W-1:0] r_cnt, n_cnt;

    function automatic logic [csvd_pkg::QPTR_W-1:0] ptr_inc(
        input logic [csvd_pkg::QPTR_W-1:0] p
    );
        ptr_inc = (p == csvd_pkg::QPTR_W'(csvd_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Advance pointers and occupancy
    always_comb begin
        wr_next = ptr_inc(r_wr);
        case (i_push)
            2'd1:    n_wr = wr_next;
            2'd2:    n_wr = ptr_inc(wr_next);
            default: n_wr = r_wr;
        endcase
        n_rd  = i_pop ? ptr_inc(r_rd) : r_rd;
        n_cnt = r_cnt + i_push - csvd_pkg::QCNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Store incoming results
    always_ff @(posedge i_clk) begin
        if (i_push != 2'd0) begin
            r_mem[r_wr] <= i_res0;
        end
        if (i_push == 2'd2) begin
            r_mem[wr_next] <= i_res1;
        end
    end

    assign o_head  = r_mem[r_rd];
    assign o_count = r_cnt;

endmodule

### rtl/core/csv_field_deframer.sv
// ----------------------------------------------------------------------------
// csv_field_deframer
// Tokenizes a CSV byte stream into field content bytes with field-end and
// record-end marks, decoding quote and backslash escapes in one field.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake              Payload
//  s_axis    in   tvalid/tready          tdata[7:0] in_byte
//  m_axis    out  tvalid/tready, tlast   tdata, tuser (see ports)
//  cfg       in   i_cfg_we               i_cfg_wdata unescape_field
//
//  One byte is taken per cycle while two queue entries are free; each byte is
//  decoded combinationally between the input register and a three-entry
//  result queue. A byte that yields two results costs an extra output
//  transfer; input keeps flowing while the queue has room.
//  Reset returns the tokenizer to field start, field counter 0, decoding
//  field 5. Held quote or backslash bytes wait for the next byte.
// ----------------------------------------------------------------------------
module csv_field_deframer #(
    parameter int MAX_FIELDS = csvd_pkg::MAX_FIELDS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [csvd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] in_byte
    // Output stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [7:0] out_byte, [11:8] field_number, [15:12] zero
    output logic [csvd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // [0] byte_valid, [1] field_end, [2] record_end
    output logic [csvd_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
    output logic                             m_axis_tlast,   // last
    // Configuration
    input  logic                             i_cfg_we,
    input  logic [csvd_pkg::CFG_W-1:0]       i_cfg_wdata
);

    localparam int FNUM_MAX  = (1 << csvd_pkg::FNUM_W) - 1;
    localparam int FIELD_CAP = (MAX_FIELDS - 1 < FNUM_MAX) ? MAX_FIELDS - 1 : FNUM_MAX;

    logic                           r_in_valid;
    logic [csvd_pkg::BYTE_W-1:0]    r_in_byte;
    csvd_pkg::t_phase               r_phase;
    logic [csvd_pkg::FNUM_W-1:0]    r_field_cnt, n_field_cnt;
    logic [csvd_pkg::CFG_W-1:0]     r_unesc;

    csvd_pkg::t_dec                 dec;
    csvd_pkg::t_result              head;
    logic [csvd_pkg::QCNT_W-1:0]    q_count, q_after;
    logic                           pop, fire;
    logic [1:0]                     push;

    // Queue handshake: decode only when two entries are free after the pop
    assign pop           = m_axis_tvalid & m_axis_tready;
    assign q_after       = q_count - csvd_pkg::QCNT_W'(pop);
    assign fire          = r_in_valid & (q_after <= csvd_pkg::QCNT_W'(1));
    assign push          = fire ? dec.count : 2'd0;
    assign s_axis_tready = ~r_in_valid | fire;

    // Hold the incoming byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    // Write the decoding field index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unesc <= csvd_pkg::UNESC_RESET;
        end else if (i_cfg_we) begin
            r_unesc <= i_cfg_wdata;
        end
    end

    csvd_decode u_decode (
        .i_byte      (r_in_byte),
        .i_phase     (r_phase),
        .i_field_num (r_field_cnt),
        .i_decode    (r_field_cnt == r_unesc),
        .o_dec       (dec)
    );

    // Advance the field counter at a field end, saturating at the cap; a record end clears it
    always_comb begin
        n_field_cnt = r_field_cnt;
        if (dec.record_done) begin
            n_field_cnt = '0;
        end else if (dec.field_done &&
                     (r_field_cnt < csvd_pkg::FNUM_W'(FIELD_CAP))) begin
            n_field_cnt = r_field_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= csvd_pkg::PH_START;
            r_field_cnt <= '0;
        end else if (fire) begin
            r_phase     <= dec.phase;
            r_field_cnt <= n_field_cnt;
        end
    end

    csvd_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res0  (dec.res0),
        .i_res1  (dec.res1),
        .i_pop   (pop),
        .o_head  (head),
        .o_count (q_count)
    );

    // Drive the output transaction from the queue head
    assign m_axis_tvalid = (q_count != '0);
    assign m_axis_tdata  = {4'b0000, head.field_number, head.data};
    assign m_axis_tuser  = {head.record_end, head.field_end, head.byte_valid};
    assign m_axis_tlast  = head.last;

endmodule

### rtl/core/csvd_checker.sv
// ----------------------------------------------------------------------------
// csvd_checker
// Port-level checks of the CSV field deframer output stream, bound to the
// top level.
// ----------------------------------------------------------------------------
module csvd_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [csvd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [csvd_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
    input logic                             m_axis_tlast
);

    // Hold a stalled output transaction
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
            $stable(m_axis_tlast))
        else $error("stalled output transaction changed");

    // A record end is also a field end
    a_rec_is_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1])
        else $error("record end without field end");

    // A result without content is a bare field end, zero byte, last of its byte
    a_empty_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |->
            m_axis_tuser[1] && m_axis_tlast && (m_axis_tdata[7:0] == 8'd0))
        else $error("empty result is not a bare field end");

    // The result after a record end belongs to field zero
    a_rec_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tuser[2] |=>
            !m_axis_tvalid || (m_axis_tdata[11:8] == 4'd0))
        else $error("field number not restarted after record end");

endmodule

bind csv_field_deframer csvd_checker u_csvd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

### tb/sv/csv_field_deframer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_field_deframer_tb
// Self-checking bench for the CSV field deframer. A cycle-free model of the
// tokenizer predicts the result tokens of every input byte; a monitor checks
// each output transaction against the oldest prediction. Directed escape
// cases come first, then random records and noise under random stalls on
// both streams, a long output hold-off, and a final stretch without stalls.
// ----------------------------------------------------------------------------
module csv_field_deframer_tb;

    localparam int MAX_FIELDS   = csvd_pkg::MAX_FIELDS_DEF;
    localparam int FIELD_CAP    = (MAX_FIELDS - 1 < 15) ? MAX_FIELDS - 1 : 15;
    localparam int DRAIN_CYCLES = 10;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [csvd_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [csvd_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic [csvd_pkg::OUT_TUSER_W-1:0] m_axis_tuser;
    logic                             m_axis_tlast;
    logic                             i_cfg_we;
    logic [csvd_pkg::CFG_W-1:0]       i_cfg_wdata;

    csv_field_deframer #(
        .MAX_FIELDS (MAX_FIELDS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // Tokenizer model state
    csvd_pkg::t_phase            tok_phase  = csvd_pkg::PH_START;
    logic [csvd_pkg::FNUM_W-1:0] fld_cnt    = '0;
    logic [csvd_pkg::CFG_W-1:0]  dec_field  = csvd_pkg::UNESC_RESET;
    csvd_pkg::t_result           step_res [2];
    int                          step_n;
    csvd_pkg::t_result           token_q [$];

    int  err_cnt      = 0;
    int  items_sent   = 0;
    bit  tx_idle_en   = 1'b1;
    bit  rx_idle_en   = 1'b1;
    int  rx_hold_left = 0;

    // Generate the clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Tokenizer model
    // ------------------------------------------------------------------------
    function automatic void emit_token(logic [7:0] b, logic valid, logic fe, logic re);
        if (step_n < 2) begin
            step_res[step_n] = '{data: b, byte_valid: valid, field_end: fe,
                                 record_end: re, field_number: fld_cnt, last: 1'b0};
            step_n++;
        end
    endfunction

    // Merge the end marks into a content token of this byte, or emit a lone end
    function automatic void close_field(logic rec);
        if (step_n > 0 && step_res[step_n-1].byte_valid && !step_res[step_n-1].field_end) begin
            step_res[step_n-1].field_end  = 1'b1;
            step_res[step_n-1].record_end = rec;
        end else begin
            emit_token(8'd0, 1'b0, 1'b1, rec);
        end
        if (rec)
            fld_cnt = '0;
        else if (fld_cnt < FIELD_CAP)
            fld_cnt = fld_cnt + 1'b1;
        tok_phase = csvd_pkg::PH_START;
    endfunction

    function automatic void quoted_char(logic [7:0] c, bit dec);
        if (c == csvd_pkg::CH_QUOTE) begin
            tok_phase = csvd_pkg::PH_Q1;
        end else if (dec && c == csvd_pkg::CH_BSL) begin
            tok_phase = csvd_pkg::PH_QBS;
        end else begin
            emit_token(c, 1'b1, 1'b0, 1'b0);
            tok_phase = csvd_pkg::PH_QUO;
        end
    endfunction

    function automatic void plain_char(logic [7:0] c, bit dec);
        if (c == csvd_pkg::CH_COMMA) begin
            close_field(1'b0);
        end else if (c == csvd_pkg::CH_NL) begin
            close_field(1'b1);
        end else if (dec && c == csvd_pkg::CH_QUOTE) begin
            tok_phase = csvd_pkg::PH_UQ;
        end else if (dec && c == csvd_pkg::CH_BSL) begin
            tok_phase = csvd_pkg::PH_UBS;
        end else begin
            emit_token(c, 1'b1, 1'b0, 1'b0);
            tok_phase = csvd_pkg::PH_UNQ;
        end
    endfunction

    // Predict the tokens of one accepted byte and queue them
    function automatic void tokenize_byte(logic [7:0] c);
        bit dec;
        dec    = (fld_cnt == dec_field);
        step_n = 0;
        case (tok_phase)
            csvd_pkg::PH_START: begin
                if (c == csvd_pkg::CH_QUOTE)
                    tok_phase = csvd_pkg::PH_QUO;
                else
                    plain_char(c, dec);
            end
            csvd_pkg::PH_UNQ: plain_char(c, dec);
            csvd_pkg::PH_UQ: begin
                emit_token(csvd_pkg::CH_QUOTE, 1'b1, 1'b0, 1'b0);
                tok_phase = csvd_pkg::PH_UNQ;
                if (c != csvd_pkg::CH_QUOTE)
                    plain_char(c, dec);
            end
            csvd_pkg::PH_UBS: begin
                if (c == csvd_pkg::CH_N) begin
                    emit_token(csvd_pkg::CH_NL, 1'b1, 1'b0, 1'b0);
                    tok_phase = csvd_pkg::PH_UNQ;
                end else begin
                    emit_token(csvd_pkg::CH_BSL, 1'b1, 1'b0, 1'b0);
                    tok_phase = csvd_pkg::PH_UNQ;
                    plain_char(c, dec);
                end
            end
            csvd_pkg::PH_QUO: quoted_char(c, dec);
            csvd_pkg::PH_Q1: begin
                if (c == csvd_pkg::CH_COMMA) begin
                    close_field(1'b0);
                end else if (c == csvd_pkg::CH_NL) begin
                    close_field(1'b1);
                end else if (dec && c == csvd_pkg::CH_QUOTE) begin
                    tok_phase = csvd_pkg::PH_Q2;
                end else begin
                    emit_token(csvd_pkg::CH_QUOTE, 1'b1, 1'b0, 1'b0);
                    quoted_char(c, dec);
                end
            end
            csvd_pkg::PH_Q2: begin
                emit_token(csvd_pkg::CH_QUOTE, 1'b1, 1'b0, 1'b0);
                if (c == csvd_pkg::CH_COMMA)
                    close_field(1'b0);
                else if (c == csvd_pkg::CH_NL)
                    close_field(1'b1);
                else if (c == csvd_pkg::CH_QUOTE)
                    tok_phase = csvd_pkg::PH_Q1;
                else
                    quoted_char(c, dec);
            end
            default: begin
                // backslash held in a quoted field
                if (c == csvd_pkg::CH_N) begin
                    emit_token(csvd_pkg::CH_NL, 1'b1, 1'b0, 1'b0);
                    tok_phase = csvd_pkg::PH_QUO;
                end else begin
                    emit_token(csvd_pkg::CH_BSL, 1'b1, 1'b0, 1'b0);
                    quoted_char(c, dec);
                end
            end
        endcase
        if (step_n > 0)
            step_res[step_n-1].last = 1'b1;
        for (int i = 0; i < step_n; i++)
            token_q.push_back(step_res[i]);
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: check output transactions, track config writes, predict input
    // ------------------------------------------------------------------------
    function automatic void check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            err_cnt++;
        end
    endfunction

    always @(posedge i_clk) begin
        csvd_pkg::t_result want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (token_q.size() == 0) begin
                    $error("unexpected result: tdata %h tuser %b tlast %b",
                           m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    err_cnt++;
                end else begin
                    want = token_q.pop_front();
                    check_field("out_byte", want.data, m_axis_tdata[7:0]);
                    check_field("byte_valid", want.byte_valid, m_axis_tuser[0]);
                    check_field("field_end", want.field_end, m_axis_tuser[1]);
                    check_field("record_end", want.record_end, m_axis_tuser[2]);
                    check_field("field_number", want.field_number, m_axis_tdata[11:8]);
                    check_field("last", want.last, m_axis_tlast);
                end
            end
            if (i_cfg_we)
                dec_field = i_cfg_wdata;
            if (s_axis_tvalid && s_axis_tready)
                tokenize_byte(s_axis_tdata);
        end
    end

    // Drive output ready: a pending long hold-off wins, else random stall bursts
    initial begin : rx_ready_gen
        int burst;
        burst = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_left > 0) begin
                m_axis_tready = 1'b0;
                rx_hold_left--;
            end else if (burst > 0) begin
                m_axis_tready = 1'b0;
                burst--;
            end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
                m_axis_tready = 1'b0;
                burst = $urandom_range(1, 11) - 1;
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    // End the run when no transaction moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        @(posedge i_rst_n);
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("csv_field_deframer: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // Offer one byte, with an optional gap, and hold it until accepted
    task automatic send_byte(logic [7:0] b);
        int gap;
        @(negedge i_clk);
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 11);
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic send_string(string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // Drop valid and wait until every predicted token has come out
    task automatic wait_until_idle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (token_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_decode_field(logic [csvd_pkg::CFG_W-1:0] idx);
        wait_until_idle();
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = idx;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    function automatic logic [7:0] pick_content_byte(bit quoted);
        case ($urandom_range(0, 15))
            0:       return csvd_pkg::CH_QUOTE;
            1:       return csvd_pkg::CH_BSL;
            2:       return csvd_pkg::CH_N;
            3:       return 8'd13;
            4, 5, 6: return 8'(8'd97 + $urandom_range(0, 25));
            7:       return quoted ? csvd_pkg::CH_COMMA : 8'd122;
            8:       return quoted ? csvd_pkg::CH_NL : 8'd121;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Send one record of random fields and content; rarely a wide one
    task automatic send_record();
        int         nf;
        int         len;
        bit         quoted;
        logic [7:0] b;
        nf = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 20) : $urandom_range(1, 6);
        for (int f = 0; f < nf; f++) begin
            quoted = $urandom_range(0, 1);
            len    = $urandom_range(0, 4);
            if (quoted)
                send_byte(csvd_pkg::CH_QUOTE);
            for (int i = 0; i < len; i++) begin
                b = pick_content_byte(quoted);
                send_byte(b);
                if (quoted && b == csvd_pkg::CH_QUOTE && $urandom_range(0, 3) != 0)
                    send_byte(csvd_pkg::CH_QUOTE);
            end
            if (quoted)
                send_byte(csvd_pkg::CH_QUOTE);
            send_byte((f == nf - 1) ? csvd_pkg::CH_NL : csvd_pkg::CH_COMMA);
        end
    endtask

    // Send a short burst of arbitrary bytes, biased toward the special codes
    task automatic send_noise();
        int n;
        n = $urandom_range(1, 8);
        repeat (n) begin
            case ($urandom_range(0, 5))
                0:       send_byte(csvd_pkg::CH_QUOTE);
                1:       send_byte(csvd_pkg::CH_COMMA);
                2:       send_byte(csvd_pkg::CH_NL);
                3:       send_byte(csvd_pkg::CH_BSL);
                default: send_byte(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    task automatic run_random(int count);
        int target;
        target = items_sent + count;
        while (items_sent < target) begin
            if ($urandom_range(0, 7) == 0)
                send_noise();
            else
                send_record();
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Escapes in the decoding field, byte extremes, empty and quoted fields
    task automatic test_directed_escapes();
        write_decode_field(4'd0);
        // field 0: quote pair plus a third quote, backslash-n, backslash-x
        send_string("\"\"\"\"\\n\\x\",");
        // field 1: byte extremes and carriage return as plain content
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'd13);
        send_byte(csvd_pkg::CH_COMMA);
        // field 2: empty
        send_byte(csvd_pkg::CH_COMMA);
        // field 3: lone quotes kept as content in a plain quoted field
        send_string("\"a\"b\"\n");
        // next record, field 0: unquoted escapes, held quote merged with end
        send_string("\\n\",");
    endtask

    // Move the decoding field while a quote is held in the stream
    task automatic test_register_change_mid_field();
        send_string("\"q\"");
        write_decode_field(4'd1);
        send_byte(csvd_pkg::CH_QUOTE);
        send_byte(csvd_pkg::CH_NL);
    endtask

    // Random records under random stalls at several decoding settings
    task automatic test_random_records();
        write_decode_field(4'd15);
        run_random(100);
        write_decode_field(csvd_pkg::UNESC_RESET);
        run_random(100);
        write_decode_field(4'($urandom_range(0, 15)));
        run_random(100);
        write_decode_field(4'($urandom_range(0, 15)));
        run_random(100);
    endtask

    // Hold the output off while the sender keeps offering bytes
    task automatic test_output_hold_off();
        tx_idle_en = 1'b0;
        @(posedge i_clk);
        rx_hold_left = HOLD_CYCLES;
        run_random(40);
        tx_idle_en = 1'b1;
    endtask

    // Finish at full rate on both streams
    task automatic test_full_rate();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        write_decode_field(4'($urandom_range(0, 15)));
        run_random(60);
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_escapes();
        test_register_change_mid_field();
        test_random_records();
        test_output_hold_off();
        test_full_rate();

        wait_until_idle();
        if (err_cnt == 0 && token_q.size() == 0) begin
            $display("csv_field_deframer: match");
        end else begin
            $display("csv_field_deframer: mismatch");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/csvd_pkg.sv
rtl/core/csvd_decode.sv
rtl/core/csvd_outq.sv
rtl/core/csv_field_deframer.sv
rtl/core/csvd_checker.sv
tb/sv/csv_field_deframer_tb.sv
